>>> rtl/ketr_pkg.sv
// Package: state encoding and shared constants for the keyed entry table.
package ketr_pkg;

  localparam int unsigned KeyBytes = 20;

  localparam logic ModeLookup = 1'b0;
  localparam logic ModeInsert = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_SWAP  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] km;
    logic [31:0] kl;
    logic [63:0] ke;
    logic [3:0]  elen;
    logic [7:0]  kind;
    logic [31:0] hits;
    logic [31:0] stamp;
    logic [31:0] handle;
  } slot_t;

  function automatic logic [63:0] extra_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[63 - 8*b -: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> rtl/keyed_entry_table_hit_count_replace.sv
// Top level: keyed entry table with hit counting and replacement.
//
// channel   direction  handshake            payload
// request   in         start_i, busy_o      mode_i, key_*_i, extra_*_i, entry_kind_i, ...
// result    out        done_o (one cycle)   matched_o, slot_index_o, found_*_o, released*_o
//
// busy_o stays high while the slots are scanned in turn (single read port), then through
// ST_WRITE on a miss (a write only for an insert), or ST_CHECK and maybe ST_SWAP on a hit.
// done_o pulses in the same cycle that busy_o falls.
// Reset clears the fill count and the state machine; slot memory needs no clearing.
// The receiver cannot stall: done_o pulses for one cycle per item.
module keyed_entry_table_hit_count_replace #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_middle_i,
  input  logic [31:0] key_low_i,
  input  logic [63:0] extra_key_i,
  input  logic [3:0]  extra_length_i,
  input  logic [7:0]  entry_kind_i,
  input  logic [31:0] stamp_minutes_i,
  input  logic [31:0] data_handle_i,
  output logic        done_o,
  output logic        matched_o,
  output logic [5:0]  slot_index_o,
  output logic [31:0] found_handle_o,
  output logic [31:0] found_stamp_o,
  output logic        released_o,
  output logic [31:0] released_handle_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ketr_pkg::slot_t mem_q [CAPACITY];
  ketr_pkg::slot_t rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  ketr_pkg::slot_t wr_data;

  ketr_pkg::state_e state_q, state_d;
  logic [CW-1:0]   filled_q, filled_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   pick_q, pick_d;
  ketr_pkg::slot_t pick_slot_q, pick_slot_d;
  ketr_pkg::slot_t hit_slot_q, hit_slot_d;
  logic [AW-1:0]   hit_idx_q, hit_idx_d;
  logic            req_mode_q;
  logic [63:0]     req_kh_q, req_km_q, req_ke_q;
  logic [31:0]     req_kl_q, req_stamp_q, req_handle_q;
  logic [3:0]      req_n_q;
  logic [7:0]      req_kind_q;
  logic            done_d, matched_d, released_d;
  logic [5:0]      slot_d;
  logic [31:0]     fh_d, fs_d, rh_d;
  logic [63:0]     m;
  logic            key_eq, first;
  logic [31:0]     diff;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  assign m      = ketr_pkg::extra_mask(req_n_q);
  assign key_eq = rd_q.kh == req_kh_q && rd_q.km == req_km_q && rd_q.kl == req_kl_q
                  && rd_q.kind == req_kind_q && ((rd_q.ke & m) == (req_ke_q & m));
  assign first  = idx_q == '0;
  assign diff   = (rd_q.hits + rd_q.stamp) - (pick_slot_q.hits + pick_slot_q.stamp);
  assign busy_o = state_q != ketr_pkg::ST_IDLE;

  always_comb begin
    state_d     = state_q;
    filled_d    = filled_q;
    idx_d       = idx_q;
    pick_d      = pick_q;
    pick_slot_d = pick_slot_q;
    hit_slot_d  = hit_slot_q;
    hit_idx_d   = hit_idx_q;
    rd_addr     = idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_data     = rd_q;
    done_d      = 1'b0;
    matched_d   = 1'b0;
    released_d  = 1'b0;
    slot_d      = '0;
    fh_d        = '0;
    fs_d        = '0;
    rh_d        = '0;
    unique case (state_q)
      ketr_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (start_i) begin
          idx_d   = '0;
          pick_d  = '0;
          state_d = (filled_q == '0) ? ketr_pkg::ST_WRITE : ketr_pkg::ST_SCAN;
        end
      end
      ketr_pkg::ST_SCAN: begin
        // read of slot idx_q issued last cycle is now in rd_q
        if (first) pick_slot_d = rd_q;
        if (key_eq) begin
          hit_slot_d = rd_q;
          hit_idx_d  = idx_q[AW-1:0];
          state_d    = ketr_pkg::ST_CHECK;
        end else begin
          if (req_mode_q == ketr_pkg::ModeLookup) begin
            if (!first && rd_q.hits < pick_slot_q.hits) begin
              pick_d = idx_q[AW-1:0];
              pick_slot_d = rd_q;
            end
          end else if (!first && diff != '0 && !diff[31]) begin
            pick_d = idx_q[AW-1:0];
            pick_slot_d = rd_q;
          end
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_d[AW-1:0];
          if (idx_d == filled_q) state_d = ketr_pkg::ST_WRITE;
        end
      end
      ketr_pkg::ST_CHECK: begin
        matched_d = 1'b1;
        if (req_mode_q == ketr_pkg::ModeInsert) begin
          wr_en          = 1'b1;
          wr_addr        = hit_idx_q;
          wr_data        = hit_slot_q;
          wr_data.handle = req_handle_q;
          wr_data.stamp  = req_stamp_q;
          slot_d         = 6'(hit_idx_q);
          released_d     = 1'b1;
          rh_d           = hit_slot_q.handle;
          done_d         = 1'b1;
          state_d        = ketr_pkg::ST_IDLE;
        end else if (pick_slot_q.hits < hit_slot_q.hits && pick_q != hit_idx_q) begin
          wr_en   = 1'b1;
          wr_addr = hit_idx_q;
          wr_data = pick_slot_q;
          state_d = ketr_pkg::ST_SWAP;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = hit_idx_q;
          wr_data      = hit_slot_q;
          wr_data.hits = hit_slot_q.hits + 32'd1;
          slot_d       = 6'(hit_idx_q);
          fh_d         = hit_slot_q.handle;
          fs_d         = hit_slot_q.stamp;
          done_d       = 1'b1;
          state_d      = ketr_pkg::ST_IDLE;
        end
      end
      ketr_pkg::ST_SWAP: begin
        matched_d    = 1'b1;
        wr_en        = 1'b1;
        wr_addr      = pick_q;
        wr_data      = hit_slot_q;
        wr_data.hits = hit_slot_q.hits + 32'd1;
        slot_d       = 6'(pick_q);
        fh_d         = hit_slot_q.handle;
        fs_d         = hit_slot_q.stamp;
        done_d       = 1'b1;
        state_d      = ketr_pkg::ST_IDLE;
      end
      ketr_pkg::ST_WRITE: begin
        if (req_mode_q == ketr_pkg::ModeLookup) begin
          done_d  = 1'b1;
        end else begin
          wr_en          = 1'b1;
          wr_data.kh     = req_kh_q;
          wr_data.km     = req_km_q;
          wr_data.kl     = req_kl_q;
          wr_data.ke     = req_ke_q & m;
          wr_data.elen   = req_n_q;
          wr_data.kind   = req_kind_q;
          wr_data.hits   = '0;
          wr_data.stamp  = req_stamp_q;
          wr_data.handle = req_handle_q;
          if (filled_q >= CW'(CAPACITY)) begin
            wr_addr    = pick_q;
            slot_d     = 6'(pick_q);
            released_d = 1'b1;
            rh_d       = pick_slot_q.handle;
          end else begin
            wr_addr  = filled_q[AW-1:0];
            slot_d   = 6'(filled_q);
            filled_d = filled_q + 1'b1;
          end
          done_d = 1'b1;
        end
        state_d = ketr_pkg::ST_IDLE;
      end
      default: state_d = ketr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ketr_pkg::ST_IDLE;
      filled_q <= '0;
      done_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      done_o   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pick_q      <= pick_d;
    pick_slot_q <= pick_slot_d;
    hit_slot_q  <= hit_slot_d;
    hit_idx_q   <= hit_idx_d;
    matched_o         <= matched_d;
    slot_index_o      <= slot_d;
    found_handle_o    <= fh_d;
    found_stamp_o     <= fs_d;
    released_o        <= released_d;
    released_handle_o <= rh_d;
    if (state_q == ketr_pkg::ST_IDLE && start_i) begin
      req_mode_q   <= mode_i;
      req_kh_q     <= key_high_i;
      req_km_q     <= key_middle_i;
      req_kl_q     <= key_low_i;
      req_ke_q     <= extra_key_i;
      req_n_q      <= (extra_length_i > 4'd8) ? 4'd8 : extra_length_i;
      req_kind_q   <= entry_kind_i;
      req_stamp_q  <= stamp_minutes_i;
      req_handle_q <= data_handle_i;
    end
  end

endmodule

>>> verif/keyed_entry_table_hit_count_replace_test.sv
// Testbench for the keyed entry table: lookups and inserts checked against a predictor.
`timescale 1ns / 1ps

module keyed_entry_table_hit_count_replace_test;

  localparam int unsigned Slots = 64;
  localparam longint unsigned CycleLimit = 2000000;

  typedef struct {
    bit        matched;
    bit [5:0]  slot;
    bit [31:0] found_handle;
    bit [31:0] found_stamp;
    bit        released;
    bit [31:0] released_handle;
  } outcome_t;

  typedef struct {
    bit [63:0] kh;
    bit [63:0] km;
    bit [31:0] kl;
    bit [63:0] ke;
    bit [3:0]  elen;
    bit [7:0]  kind;
  } key_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        mode_i;
  logic [63:0] key_high_i;
  logic [63:0] key_middle_i;
  logic [31:0] key_low_i;
  logic [63:0] extra_key_i;
  logic [3:0]  extra_length_i;
  logic [7:0]  entry_kind_i;
  logic [31:0] stamp_minutes_i;
  logic [31:0] data_handle_i;
  logic        done_o;
  logic        matched_o;
  logic [5:0]  slot_index_o;
  logic [31:0] found_handle_o;
  logic [31:0] found_stamp_o;
  logic        released_o;
  logic [31:0] released_handle_o;

  keyed_entry_table_hit_count_replace u_top (.*);

  bit [63:0] tbl_kh [Slots];
  bit [63:0] tbl_km [Slots];
  bit [31:0] tbl_kl [Slots];
  bit [63:0] tbl_ke [Slots];
  bit [3:0]  tbl_elen [Slots];
  bit [7:0]  tbl_kind [Slots];
  bit [31:0] tbl_hits [Slots];
  bit [31:0] tbl_stamp [Slots];
  bit [31:0] tbl_handle [Slots];
  int unsigned filled;

  outcome_t pending_outcomes[$];
  key_t     known_keys[$];
  int unsigned errors;
  longint unsigned cycles;
  int unsigned gap_bias;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit [63:0] byte_mask(bit [3:0] n);
    bit [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < n) m[63 - 8*b -: 8] = 8'hFF;
    end
    return m;
  endfunction

  task automatic report(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic swap_slots(int unsigned a, int unsigned b);
    bit [63:0] t64;
    bit [31:0] t32;
    bit [7:0]  t8;
    bit [3:0]  t4;
    t64 = tbl_kh[a]; tbl_kh[a] = tbl_kh[b]; tbl_kh[b] = t64;
    t64 = tbl_km[a]; tbl_km[a] = tbl_km[b]; tbl_km[b] = t64;
    t32 = tbl_kl[a]; tbl_kl[a] = tbl_kl[b]; tbl_kl[b] = t32;
    t64 = tbl_ke[a]; tbl_ke[a] = tbl_ke[b]; tbl_ke[b] = t64;
    t4 = tbl_elen[a]; tbl_elen[a] = tbl_elen[b]; tbl_elen[b] = t4;
    t8 = tbl_kind[a]; tbl_kind[a] = tbl_kind[b]; tbl_kind[b] = t8;
    t32 = tbl_hits[a]; tbl_hits[a] = tbl_hits[b]; tbl_hits[b] = t32;
    t32 = tbl_stamp[a]; tbl_stamp[a] = tbl_stamp[b]; tbl_stamp[b] = t32;
    t32 = tbl_handle[a]; tbl_handle[a] = tbl_handle[b]; tbl_handle[b] = t32;
  endtask

  task automatic predict_table(bit mode, key_t k, bit [31:0] stamp, bit [31:0] handle);
    outcome_t o;
    bit [3:0] n;
    bit [63:0] m;
    bit [31:0] d;
    int unsigned pick;
    int unsigned at;
    o = '{default: 0};
    n = (k.elen > 8) ? 4'd8 : k.elen;
    m = byte_mask(n);
    pick = 0;
    for (int unsigned i = 0; i < filled; i++) begin
      if (tbl_kh[i] == k.kh && tbl_km[i] == k.km && tbl_kl[i] == k.kl &&
          tbl_kind[i] == k.kind && (tbl_ke[i] & m) == (k.ke & m)) begin
        o.matched = 1'b1;
        if (mode == ketr_pkg::ModeLookup) begin
          at = i;
          if (tbl_hits[pick] < tbl_hits[i]) begin
            swap_slots(pick, i);
            at = pick;
          end
          tbl_hits[at] = tbl_hits[at] + 1;
          o.slot = at[5:0];
          o.found_handle = tbl_handle[at];
          o.found_stamp = tbl_stamp[at];
        end else begin
          o.slot = i[5:0];
          o.released = 1'b1;
          o.released_handle = tbl_handle[i];
          tbl_handle[i] = handle;
          tbl_stamp[i] = stamp;
        end
        pending_outcomes.push_back(o);
        return;
      end
      if (mode == ketr_pkg::ModeLookup) begin
        if (tbl_hits[i] < tbl_hits[pick]) pick = i;
      end else begin
        d = (tbl_hits[i] + tbl_stamp[i]) - (tbl_hits[pick] + tbl_stamp[pick]);
        if (d != 0 && !d[31]) pick = i;
      end
    end
    if (mode == ketr_pkg::ModeInsert) begin
      if (filled >= Slots) begin
        at = pick;
        o.released = 1'b1;
        o.released_handle = tbl_handle[at];
      end else begin
        at = filled;
        filled++;
      end
      tbl_kh[at] = k.kh;
      tbl_km[at] = k.km;
      tbl_kl[at] = k.kl;
      tbl_ke[at] = k.ke & m;
      tbl_elen[at] = n;
      tbl_kind[at] = k.kind;
      tbl_hits[at] = 0;
      tbl_stamp[at] = stamp;
      tbl_handle[at] = handle;
      o.slot = at[5:0];
    end
    pending_outcomes.push_back(o);
  endtask

  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        report("unexpected result", '0, '0);
      end else begin
        w = pending_outcomes.pop_front();
        if (matched_o !== w.matched) report("matched", 32'(matched_o), 32'(w.matched));
        if (slot_index_o !== w.slot) begin
          report("slot_index", 32'(slot_index_o), 32'(w.slot));
        end
        if (found_handle_o !== w.found_handle) begin
          report("found_handle", found_handle_o, w.found_handle);
        end
        if (found_stamp_o !== w.found_stamp) report("found_stamp", found_stamp_o, w.found_stamp);
        if (released_o !== w.released) report("released", 32'(released_o), 32'(w.released));
        if (released_handle_o !== w.released_handle) begin
          report("released_handle", released_handle_o, w.released_handle);
        end
      end
    end
  end

  function automatic key_t random_key();
    key_t k;
    k.kh = {$urandom, $urandom};
    k.km = {$urandom, $urandom};
    k.kl = $urandom;
    k.ke = {$urandom, $urandom};
    k.elen = 4'($urandom_range(0, 15));
    k.kind = 8'($urandom_range(0, 255));
    return k;
  endfunction

  task automatic idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < gap_bias) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else if (r < gap_bias + 4) repeat ($urandom_range(20, 150)) @(negedge clk_i);
  endtask

  task automatic send_item(bit mode, key_t k, bit [31:0] stamp, bit [31:0] handle);
    idle_gap();
    mode_i = mode;
    key_high_i = k.kh;
    key_middle_i = k.km;
    key_low_i = k.kl;
    extra_key_i = k.ke;
    extra_length_i = k.elen;
    entry_kind_i = k.kind;
    stamp_minutes_i = stamp;
    data_handle_i = handle;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_table(mode, k, stamp, handle);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Perturb a known key: flip one bit of one field, pick a new extra length, or keep it as is.
  function automatic key_t variant_key(key_t k);
    key_t v;
    v = k;
    case ($urandom_range(0, 9))
      0: v.kh[$urandom_range(0, 63)] ^= 1'b1;
      1: v.km[$urandom_range(0, 63)] ^= 1'b1;
      2: v.kl[$urandom_range(0, 31)] ^= 1'b1;
      3: v.kind ^= 8'(1 << $urandom_range(0, 7));
      4: v.ke[$urandom_range(0, 63)] ^= 1'b1;
      5: v.elen = 4'($urandom_range(0, 15));
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    key_t k;
    key_t z;
    z = '{default: 0};
    send_item(ketr_pkg::ModeLookup, z, 0, 0);
    send_item(ketr_pkg::ModeInsert, z, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ketr_pkg::ModeLookup, z, 0, 0);
    send_item(ketr_pkg::ModeInsert, z, 0, 32'h1);
    k = '{kh: '1, km: '1, kl: '1, ke: '1, elen: 4'd15, kind: 8'hFF};
    send_item(ketr_pkg::ModeInsert, k, 32'h7FFF_FFFF, 32'hAAAA_5555);
    k.elen = 4'd8;
    send_item(ketr_pkg::ModeLookup, k, 0, 0);
    k.elen = 4'd3;
    k.ke = 64'hFFFF_FF00_0000_0000;
    send_item(ketr_pkg::ModeLookup, k, 0, 0);
    send_item(ketr_pkg::ModeInsert, k, 32'h8000_0000, 32'h5555_AAAA);
    k.ke = 64'hFFFF_FF12_3456_789A;
    send_item(ketr_pkg::ModeLookup, k, 0, 0);
    k.elen = 4'd0;
    send_item(ketr_pkg::ModeLookup, k, 0, 0);
    k.kind = 8'h00;
    send_item(ketr_pkg::ModeLookup, k, 0, 0);
    for (int i = 0; i < 4; i++) send_item(ketr_pkg::ModeLookup, z, 0, 0);
    send_item(ketr_pkg::ModeLookup, known_keys.size() ? known_keys[0] : z, 0, 0);
  endtask

  task automatic test_fill_and_evict();
    key_t k;
    for (int i = 0; i < 70; i++) begin
      k = random_key();
      known_keys.push_back(k);
      send_item(ketr_pkg::ModeInsert, k, $urandom, $urandom);
    end
  endtask

  task automatic test_hit_swap();
    for (int i = 0; i < 300; i++) begin
      send_item(ketr_pkg::ModeLookup, known_keys[$urandom_range(0, known_keys.size() - 1)],
                0, 0);
    end
  endtask

  task automatic test_random_mix(int unsigned count);
    key_t k;
    int unsigned r;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        k = random_key();
        if (known_keys.size() < 200) known_keys.push_back(k);
      end else begin
        k = variant_key(known_keys[$urandom_range(0, known_keys.size() - 1)]);
      end
      if ($urandom_range(0, 2) == 0) begin
        send_item(ketr_pkg::ModeInsert, k,
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200), $urandom);
      end else begin
        send_item(ketr_pkg::ModeLookup, k, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    filled = 0;
    gap_bias = 30;
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = 1'b0;
    key_high_i = '0;
    key_middle_i = '0;
    key_low_i = '0;
    extra_key_i = '0;
    extra_length_i = '0;
    entry_kind_i = '0;
    stamp_minutes_i = '0;
    data_handle_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_and_evict();
    test_hit_swap();
    gap_bias = 0;
    test_random_mix(300);
    gap_bias = 40;
    test_random_mix(900);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
